@@ hdl/text_console_engine_defines.svh @@
// Assertion macros used by the text console engine checker.
`ifndef TEXT_CONSOLE_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_ENGINE_DEFINES_SVH

// clocked check, off while in reset
`define TCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("text console check failed");

// clocked check, active in reset too
`define TCE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("text console check failed");

`endif

@@ hdl/tce_pkg.sv @@
// Types and constants of the text console engine.
`default_nettype none
package tce_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int REQ_W  = 2;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CELL_W-1:0] TEXT_ATTR    = 16'h0700;
  localparam logic [CELL_W-1:0] OVERLAY_CELL = 16'h7020;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [REQ_W-1:0] REQ_PUT       = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BACKSPACE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ      = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] read_addr;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
  } out_word_t;

endpackage
`default_nettype wire

@@ hdl/text_console_engine.sv @@
// Text console engine: screen store with cursor overlay, put/backspace/clear/read.
//
// Channels: in_valid/in_ready/in_word carry one request word, out_valid/
// out_ready/out_word return one result word per request (cursor after the
// request, cell data for reads). cfg_valid/cfg_data write the protected
// start position; cfg_ready is always high.
// One request is worked on at a time; the screen lives in a single-port-
// write, registered-read RAM of COLS*ROWS cells.
// Steps per request, accept to result register:
//   put without scroll, plain backspace, out-of-range read: result step only
//   read: RAM read wait, then result step
//   put with scroll, clear: sweep, one RAM copy or blank per cycle, then drain
//   backspace from column 0: scan, then check, per cell (registered RAM read)
// The cursor overlay is kept in registers and shown on reads, never stored.
// Reset: a clearing pass blanks every cell with in_ready low; configuration
// writes are taken during it.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and finishes up to its final result step.
`default_nettype none
module text_console_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tce_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tce_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [tce_pkg::ADDR_W-1:0] cfg_data
);

  localparam int AW = tce_pkg::ADDR_W;
  localparam int CW = tce_pkg::COL_W;
  localparam int RW = tce_pkg::ROW_W;
  localparam int DW = tce_pkg::CELL_W;

  localparam logic [AW-1:0] LAST_CELL = AW'(tce_pkg::CELLS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'(tce_pkg::CELLS - tce_pkg::COLS);
  localparam logic [AW-1:0] NUM_CELLS = AW'(tce_pkg::CELLS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(tce_pkg::COLS);
  localparam logic [CW-1:0] LAST_COL  = CW'(tce_pkg::COLS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(tce_pkg::ROWS - 1);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_SWEEP  = 3'd1;
  localparam logic [ST_W-1:0] ST_DRAIN  = 3'd2;
  localparam logic [ST_W-1:0] ST_SCAN   = 3'd3;
  localparam logic [ST_W-1:0] ST_CHECK  = 3'd4;
  localparam logic [ST_W-1:0] ST_RDWAIT = 3'd5;
  localparam logic [ST_W-1:0] ST_FINISH = 3'd6;

  logic [DW-1:0] mem [tce_pkg::CELLS];

  logic [ST_W-1:0] state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic            ovl_on_r, ovl_on_nxt;
  logic [AW-1:0]   prot_r, prot_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            copy_r, copy_nxt;
  logic            init_r, init_nxt;
  logic            wr_en_r, wr_en_nxt;
  logic [AW-1:0]   wr_addr_r, wr_addr_nxt;
  logic            wr_blank_r, wr_blank_nxt;
  logic [DW-1:0]   data_r, data_nxt;
  logic            hit_r, hit_nxt;
  logic [DW-1:0]   rdata_r;
  logic            out_valid_r, out_valid_nxt;
  tce_pkg::out_word_t out_word_r, out_word_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] here;
  logic          wrap;

  assign here = AW'(row_r) * ROW_STEP + AW'(col_r);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    ovl_on_nxt   = ovl_on_r;
    prot_nxt     = prot_r;
    ptr_nxt      = ptr_r;
    copy_nxt     = copy_r;
    init_nxt     = init_r;
    wr_en_nxt    = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    wr_blank_nxt = wr_blank_r;
    data_nxt     = data_r;
    hit_nxt      = hit_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt = out_word_r;
    mem_we       = 1'b0;
    mem_wa       = here;
    mem_wd       = tce_pkg::BLANK_CELL;
    rd_addr      = '0;
    wrap         = 1'b0;

    if (wr_en_r) begin
      mem_we = 1'b1;
      mem_wa = wr_addr_r;
      mem_wd = wr_blank_r ? tce_pkg::BLANK_CELL : rdata_r;
    end

    if (cfg_valid) begin
      prot_nxt = cfg_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = '0;
          case (in_word.req_type)
            tce_pkg::REQ_PUT: begin
              ovl_on_nxt = 1'b1;
              state_nxt  = ST_FINISH;
              if (in_word.char_code == tce_pkg::NEWLINE_CODE) begin
                col_nxt = '0;
                wrap    = 1'b1;
              end else begin
                mem_we = 1'b1;
                mem_wa = here;
                mem_wd = tce_pkg::TEXT_ATTR | DW'(in_word.char_code);
                if (col_r == LAST_COL) begin
                  col_nxt = '0;
                  wrap    = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
              if (wrap) begin
                if (row_r == LAST_ROW) begin
                  ptr_nxt   = '0;
                  copy_nxt  = 1'b1;
                  state_nxt = ST_SWEEP;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
            tce_pkg::REQ_BACKSPACE: begin
              ovl_on_nxt = 1'b1;
              state_nxt  = ST_FINISH;
              if (here > prot_r) begin
                if (col_r == '0) begin
                  if (row_r != '0) begin
                    row_nxt   = row_r - 1'b1;
                    col_nxt   = LAST_COL;
                    state_nxt = ST_SCAN;
                  end
                end else begin
                  col_nxt = col_r - 1'b1;
                  mem_we  = 1'b1;
                  mem_wa  = here - 1'b1;
                  mem_wd  = tce_pkg::BLANK_CELL;
                end
              end
            end
            tce_pkg::REQ_CLEAR: begin
              ovl_on_nxt = 1'b0;
              col_nxt    = '0;
              row_nxt    = '0;
              ptr_nxt    = '0;
              copy_nxt   = 1'b0;
              state_nxt  = ST_SWEEP;
            end
            default: begin
              if (in_word.read_addr < NUM_CELLS) begin
                rd_addr   = in_word.read_addr;
                hit_nxt   = ovl_on_r && (in_word.read_addr == here);
                state_nxt = ST_RDWAIT;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        rd_addr      = (ptr_r < LAST_BASE) ? ptr_r + ROW_STEP : '0;
        wr_en_nxt    = 1'b1;
        wr_addr_nxt  = ptr_r;
        wr_blank_nxt = !copy_r || (ptr_r >= LAST_BASE);
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_DRAIN;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = init_r ? ST_IDLE : ST_FINISH;
        init_nxt  = 1'b0;
      end
      ST_SCAN: begin
        rd_addr   = here;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (rdata_r == tce_pkg::BLANK_CELL && col_r != '0) begin
          col_nxt   = col_r - 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = here;
          mem_wd    = tce_pkg::BLANK_CELL;
          state_nxt = ST_FINISH;
        end
      end
      ST_RDWAIT: begin
        data_nxt  = hit_r ? tce_pkg::OVERLAY_CELL : rdata_r;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.cursor_col = col_r;
          out_word_nxt.cursor_row = row_r;
          out_word_nxt.cell_data  = data_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      col_r       <= '0;
      row_r       <= '0;
      ovl_on_r    <= 1'b0;
      prot_r      <= '0;
      ptr_r       <= '0;
      copy_r      <= 1'b0;
      init_r      <= 1'b1;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ovl_on_r    <= ovl_on_nxt;
      prot_r      <= prot_nxt;
      ptr_r       <= ptr_nxt;
      copy_r      <= copy_nxt;
      init_r      <= init_nxt;
      wr_en_r     <= wr_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    wr_blank_r <= wr_blank_nxt;
    data_r     <= data_nxt;
    hit_r      <= hit_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

@@ hdl/text_console_engine_chk.sv @@
// Port-level checker for the text console engine, bound to the top level.
`default_nettype none
`include "text_console_engine_defines.svh"
module text_console_engine_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tce_pkg::out_word_t out_word
);

  localparam logic [tce_pkg::COL_W-1:0] NUM_COLS = tce_pkg::COL_W'(tce_pkg::COLS);
  localparam logic [tce_pkg::ROW_W-1:0] NUM_ROWS = tce_pkg::ROW_W'(tce_pkg::ROWS);

  `TCE_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_word)))
  `TCE_ASSERT_ALWAYS(a_reset_quiet, clk, (!rst_n |=> !in_ready && !out_valid))
  `TCE_ASSERT(a_one_at_a_time, clk, rst_n, (in_valid && in_ready |=> !in_ready))
  `TCE_ASSERT(a_cursor_range, clk, rst_n, (out_valid |-> (out_word.cursor_col < NUM_COLS) && (out_word.cursor_row < NUM_ROWS)))

endmodule

bind text_console_engine text_console_engine_chk u_chk (.*);
`default_nettype wire

@@ sim/text_console_engine_tb.sv @@
// Self-checking testbench for text_console_engine with a shadow screen scoreboard.
`timescale 1ns / 100ps

module text_console_engine_tb;

  localparam int STALL_LIMIT = 25000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 20;

  class console_shadow;
    logic [tce_pkg::CELL_W-1:0] cells [tce_pkg::CELLS];
    int                         col;
    int                         row;
    bit                         ovl_on;
    logic [tce_pkg::CELL_W-1:0] ovl_saved;
    int                         ovl_pos;
    int                         guard_pos;
    int                         errors;
    tce_pkg::out_word_t         pending_status[$];

    function new();
      wipe();
      guard_pos = 0;
      errors = 0;
    endfunction

    function int cursor_pos();
      return row * tce_pkg::COLS + col;
    endfunction

    function void wipe();
      for (int i = 0; i < tce_pkg::CELLS; i++) cells[i] = tce_pkg::BLANK_CELL;
      col = 0;
      row = 0;
      ovl_on = 1'b0;
      ovl_saved = '0;
      ovl_pos = 0;
    endfunction

    function void lift_overlay();
      if (ovl_on) begin
        if (ovl_pos < tce_pkg::CELLS) cells[ovl_pos] = ovl_saved;
        ovl_on = 1'b0;
      end
    endfunction

    function void paint_overlay();
      int p;
      p = cursor_pos();
      lift_overlay();
      ovl_pos = p;
      ovl_saved = cells[p];
      cells[p] = tce_pkg::OVERLAY_CELL;
      ovl_on = 1'b1;
    endfunction

    function void scroll_screen();
      for (int i = 0; i < tce_pkg::CELLS - tce_pkg::COLS; i++)
        cells[i] = cells[i + tce_pkg::COLS];
      for (int i = tce_pkg::CELLS - tce_pkg::COLS; i < tce_pkg::CELLS; i++)
        cells[i] = tce_pkg::BLANK_CELL;
      row = tce_pkg::ROWS - 1;
    endfunction

    function void put_char(logic [tce_pkg::CHAR_W-1:0] c);
      lift_overlay();
      if (c == tce_pkg::NEWLINE_CODE) begin
        col = 0;
        row++;
      end else begin
        cells[cursor_pos()] = tce_pkg::TEXT_ATTR | {8'h00, c};
        col++;
        if (col >= tce_pkg::COLS) begin
          col = 0;
          row++;
        end
      end
      if (row >= tce_pkg::ROWS) scroll_screen();
      paint_overlay();
    endfunction

    function void back_space();
      lift_overlay();
      if (cursor_pos() > guard_pos) begin
        if (col == 0) begin
          if (row > 0) begin
            row--;
            col = tce_pkg::COLS - 1;
            while (cells[cursor_pos()] == tce_pkg::BLANK_CELL && col > 0) col--;
            cells[cursor_pos()] = tce_pkg::BLANK_CELL;
          end
        end else begin
          col--;
          cells[cursor_pos()] = tce_pkg::BLANK_CELL;
        end
      end
      paint_overlay();
    endfunction

    function void note_request(tce_pkg::in_word_t w);
      tce_pkg::out_word_t         r;
      logic [tce_pkg::CELL_W-1:0] data;
      data = '0;
      case (w.req_type)
        tce_pkg::REQ_PUT:       put_char(w.char_code);
        tce_pkg::REQ_BACKSPACE: back_space();
        tce_pkg::REQ_CLEAR:     wipe();
        tce_pkg::REQ_READ:      if (w.read_addr < tce_pkg::CELLS) data = cells[w.read_addr];
        default:                ;
      endcase
      r.cursor_col = tce_pkg::COL_W'(col);
      r.cursor_row = tce_pkg::ROW_W'(row);
      r.cell_data  = data;
      pending_status.push_back(r);
    endfunction

    task report(string what, int want, int got);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
      errors++;
    endtask

    task check_result(tce_pkg::out_word_t got);
      tce_pkg::out_word_t want;
      if (pending_status.size() == 0) begin
        report("result word with nothing outstanding", 0, int'(got));
        return;
      end
      want = pending_status.pop_front();
      if (want.cursor_col != got.cursor_col)
        report("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
      if (want.cursor_row != got.cursor_row)
        report("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
      if (want.cell_data != got.cell_data)
        report("cell_data", int'(want.cell_data), int'(got.cell_data));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  tce_pkg::in_word_t          in_word = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  tce_pkg::out_word_t         out_word;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [tce_pkg::ADDR_W-1:0] cfg_data = '0;

  console_shadow shadow = new();
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  int            sent_count = 0;
  int            idle_cycles = 0;

  text_console_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(out_word);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("text_console_engine regression: fail");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(tce_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(w);
    sent_count++;
  endtask

  task automatic put_byte(logic [tce_pkg::CHAR_W-1:0] c);
    tce_pkg::in_word_t w;
    w.req_type  = tce_pkg::REQ_PUT;
    w.char_code = c;
    w.read_addr = tce_pkg::ADDR_W'($urandom);
    send_word(w);
  endtask

  task automatic do_backspace();
    tce_pkg::in_word_t w;
    w.req_type  = tce_pkg::REQ_BACKSPACE;
    w.char_code = tce_pkg::CHAR_W'($urandom);
    w.read_addr = tce_pkg::ADDR_W'($urandom);
    send_word(w);
  endtask

  task automatic do_clear();
    tce_pkg::in_word_t w;
    w.req_type  = tce_pkg::REQ_CLEAR;
    w.char_code = tce_pkg::CHAR_W'($urandom);
    w.read_addr = tce_pkg::ADDR_W'($urandom);
    send_word(w);
  endtask

  task automatic read_at(int a);
    tce_pkg::in_word_t w;
    w.req_type  = tce_pkg::REQ_READ;
    w.char_code = tce_pkg::CHAR_W'($urandom);
    w.read_addr = tce_pkg::ADDR_W'(a);
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(int guard);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= tce_pkg::ADDR_W'(guard);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.guard_pos = guard;
  endtask

  function automatic int near_cursor();
    int g;
    g = shadow.cursor_pos() - int'($urandom_range(0, 40));
    return (g < 0) ? 0 : g;
  endfunction

  task automatic random_action();
    int pick;
    int n;
    int a;
    tce_pkg::in_word_t w;
    pick = int'($urandom_range(0, 99));
    if (pick < 40) begin
      if ($urandom_range(0, 9) == 0) n = int'($urandom_range(60, 90));
      else n = int'($urandom_range(1, 20));
      repeat (n) put_byte(($urandom_range(0, 2) == 0) ? 8'h20 : tce_pkg::CHAR_W'($urandom));
    end else if (pick < 55) begin
      repeat ($urandom_range(1, 12)) put_byte(tce_pkg::NEWLINE_CODE);
    end else if (pick < 70) begin
      // a newline first lands on column 0, so backspace scans the row above
      if ($urandom_range(0, 1) == 1) put_byte(tce_pkg::NEWLINE_CODE);
      repeat ($urandom_range(1, 6)) do_backspace();
    end else if (pick < 85) begin
      read_at(shadow.cursor_pos());
      a = shadow.cursor_pos() - int'($urandom_range(0, 3));
      read_at((a < 0) ? 0 : a);
      read_at(int'($urandom_range(0, 2047)));
    end else if (pick < 88) begin
      do_clear();
    end else begin
      w.req_type  = tce_pkg::REQ_W'($urandom);
      w.char_code = tce_pkg::CHAR_W'($urandom);
      w.read_addr = tce_pkg::ADDR_W'($urandom);
      send_word(w);
    end
  endtask

  task automatic stream(int items);
    int target;
    target = sent_count + items;
    while (sent_count < target) random_action();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    configure(0);

    put_byte(8'h41);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h20);
    read_at(0);
    read_at(4);
    read_at(tce_pkg::CELLS - 1);
    read_at(tce_pkg::CELLS);
    read_at(2047);
    put_byte(tce_pkg::NEWLINE_CODE);
    repeat (4) do_backspace();
    do_clear();
    read_at(0);
    do_backspace();
    read_at(0);

    configure(tce_pkg::CELLS - 1);
    hold_req = 1'b1;
    stream(55);
    configure(int'($urandom_range(0, tce_pkg::CELLS - 1)));
    stream(55);
    configure(near_cursor());
    stream(55);
    configure(0);
    stream(40);
    configure(near_cursor());
    calm = 1'b1;
    stream(45);

    in_valid <= 1'b0;
    while (shadow.pending_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_status.size() == 0) begin
      $display("text_console_engine regression: pass");
    end else begin
      $display("text_console_engine regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tce_pkg.sv
hdl/text_console_engine.sv
hdl/text_console_engine_chk.sv
sim/text_console_engine_tb.sv
